// ----- hw/rtl/pms_pkg.sv -----
// pms_pkg: shared constants, types and the preset send tables for the
// periodic message scheduler. no dependencies.
package pms_pkg;

    // defaults for the top level parameters
    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_TICK_BITS   = 32;

    // input item opcodes
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_WR_SEND  = 2'd1;
    localparam logic [1:0] OP_WR_SAVE  = 2'd2;
    localparam logic [1:0] OP_PRESET   = 2'd3;

    // link modes
    localparam logic [1:0] LINK_FWD    = 2'd0;
    localparam logic [1:0] LINK_LOCAL  = 2'd1;
    localparam logic [1:0] LINK_REMOTE = 2'd2;

    // configuration register indexes
    localparam logic REG_LINK_MODE    = 1'b0;
    localparam logic REG_ACTIVE_COUNT = 1'b1;

    // reset values
    localparam logic [1:0]  LINK_MODE_RESET    = LINK_REMOTE;
    localparam logic [4:0]  ACTIVE_COUNT_RESET = 5'd11;
    localparam logic [31:0] DEFAULT_PERIOD     = 32'd1000;

    // port widths
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 8;
    localparam int CFG_DATA_W = 5;

    // preset tables
    localparam int         PRESET_LEN      = 11;
    localparam logic [2:0] PRESET_FIRST_ID = 3'd1;
    localparam logic [2:0] PRESET_LAST_ID  = 3'd6;

    localparam logic [31:0] PRESET_TAB [0:5][0:10] = '{
        '{32'd100, 32'd100, 32'd100, 32'd100, 32'd100, 32'd100,
          32'd100, 32'd100, 32'd100, 32'd100, 32'd100},
        '{32'd100, 32'd1000, 32'd1000, 32'd50, 32'd500, 32'd100,
          32'd100, 32'd500, 32'd1000, 32'd1000, 32'd1000},
        '{32'd100, 32'd200, 32'd1000, 32'd200, 32'd100, 32'd100,
          32'd100, 32'd1000, 32'd200, 32'd100, 32'd1000},
        '{32'd100, 32'd1000, 32'd100, 32'd1000, 32'd1000, 32'd500,
          32'd1000, 32'd1000, 32'd1000, 32'd1000, 32'd1000},
        '{32'd1000, 32'd0, 32'd500, 32'd0, 32'd0, 32'd0,
          32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
        '{32'd100, 32'd100, 32'd100, 32'd100, 32'd100, 32'd100,
          32'd100, 32'd100, 32'd100, 32'd100, 32'd100}
    };

    // controller to datapath commands
    typedef struct packed {
        logic capture;    // latch tick and preset id of the accepted item
        logic wr_send;    // write one send period
        logic wr_save;    // write one save period
        logic commit;     // take the due entry at the scan index
        logic flush;      // push the held result as last of tick
        logic preset_wr;  // write one preset send period
    } pms_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic due;
        logic hold_valid;
        logic out_free;
        logic scan_done;
        logic preset_done;
    } pms_status_t;

    function automatic logic [31:0] preset_period(input logic [2:0] pid,
                                                  input logic [3:0] idx);
        logic [2:0]  row;
        logic [31:0] val;
        row = pid - PRESET_FIRST_ID;
        val = 32'd0;
        if (pid >= PRESET_FIRST_ID && pid <= PRESET_LAST_ID && 32'(idx) < 32'(PRESET_LEN))
        begin
            val = PRESET_TAB[row][idx];
        end
        return val;
    endfunction

endpackage

// ----- hw/rtl/pms_ctrl.sv -----
// pms_ctrl: controller state machine of the periodic message scheduler.
// depends on pms_pkg for opcodes and the command and status structs.
module pms_ctrl #(
    parameter int MAX_ENTRIES = pms_pkg::DEF_MAX_ENTRIES
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           opcode,
    input  logic [2:0]                           preset_id,
    input  pms_pkg::pms_status_t                 status,
    output pms_pkg::pms_cmd_t                    cmd,
    output logic [$clog2(MAX_ENTRIES + 1)-1:0]   cnt
);
    import pms_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_PRESET = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign cnt      = cnt_reg;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    cnt_next    = '0;
                    case (opcode)
                        OP_TICK:    state_next  = ST_SCAN;
                        OP_WR_SEND: cmd.wr_send = 1'b1;
                        OP_WR_SAVE: cmd.wr_save = 1'b1;
                        OP_PRESET:
                        begin
                            if (preset_id >= PRESET_FIRST_ID && preset_id <= PRESET_LAST_ID)
                            begin
                                state_next = ST_PRESET;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    if (!status.hold_valid)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (status.out_free)
                    begin
                        cmd.flush  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (!status.due)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                else if (!status.hold_valid || status.out_free)
                begin
                    cmd.commit = 1'b1;
                    cnt_next   = cnt_reg + CNT_W'(1);
                end
            end
            ST_PRESET:
            begin
                if (status.preset_done)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.preset_wr = 1'b1;
                    cnt_next      = cnt_reg + CNT_W'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- hw/rtl/pms_dp.sv -----
// pms_dp: datapath of the periodic message scheduler: entry tables, config
// registers, due test, held result and output register. depends on pms_pkg.
module pms_dp #(
    parameter int MAX_ENTRIES = pms_pkg::DEF_MAX_ENTRIES,
    parameter int TICK_BITS   = pms_pkg::DEF_TICK_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  pms_pkg::pms_cmd_t                      cmd,
    input  logic [$clog2(MAX_ENTRIES + 1)-1:0]     cnt,
    input  logic [31:0]                            tick_value,
    input  logic [3:0]                             entry_index,
    input  logic [31:0]                            period_value,
    input  logic [2:0]                             preset_id,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_index,
    input  logic [pms_pkg::CFG_DATA_W-1:0]         cfg_data,
    output pms_pkg::pms_status_t                   status,
    input  logic                                   out_ready,
    output logic                                   out_valid,
    output logic [pms_pkg::OUT_DATA_W-1:0]         out_data,
    output logic                                   out_last
);
    import pms_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [TICK_BITS-1:0] tx_period_reg    [MAX_ENTRIES];
    logic [TICK_BITS-1:0] store_period_reg [MAX_ENTRIES];
    logic [TICK_BITS-1:0] last_send_reg    [MAX_ENTRIES];
    logic [TICK_BITS-1:0] last_save_reg    [MAX_ENTRIES];

    logic [1:0]           link_mode_reg;
    logic [4:0]           active_count_reg;
    logic [TICK_BITS-1:0] now_reg;
    logic [2:0]           pid_reg;
    logic                 hold_valid_reg;
    logic [3:0]           hold_idx_reg;
    logic [2:0]           hold_route_reg;   // flash, radio, usb
    logic                 out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                 out_last_reg;

    logic [CNT_W-1:0]     limit;
    logic [IDX_W-1:0]     rd_idx;
    logic [IDX_W-1:0]     wr_idx;
    logic                 wr_in_range;
    logic [TICK_BITS-1:0] send_elapsed;
    logic [TICK_BITS-1:0] save_elapsed;
    logic                 snd_due;
    logic                 sav_due;
    logic [2:0]           route;
    logic                 push;
    logic                 out_free;

    // entries in use, saturated to the table depth
    assign limit = (32'(active_count_reg) > 32'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                              : CNT_W'(active_count_reg);

    assign status.scan_done   = (cnt >= limit);
    assign status.preset_done = (cnt >= limit) || (32'(cnt) >= 32'(PRESET_LEN));

    assign rd_idx      = status.scan_done ? '0 : cnt[IDX_W-1:0];
    assign wr_idx      = IDX_W'(entry_index);
    assign wr_in_range = (32'(entry_index) < 32'(MAX_ENTRIES));

    // wrapping elapsed time against each period
    assign send_elapsed = now_reg - last_send_reg[rd_idx];
    assign save_elapsed = now_reg - last_save_reg[rd_idx];
    assign snd_due = (tx_period_reg[rd_idx] != '0) && (send_elapsed >= tx_period_reg[rd_idx]);
    assign sav_due = (store_period_reg[rd_idx] != '0) &&
                     (save_elapsed >= store_period_reg[rd_idx]);

    always_comb
    begin
        route = 3'b000;
        if (snd_due && sav_due)
        begin
            route = 3'b110;
        end
        else if (sav_due)
        begin
            route = 3'b100;
        end
        else
        begin
            case (link_mode_reg)
                LINK_FWD:    route = 3'b001;
                LINK_LOCAL:  route = 3'b001;
                LINK_REMOTE: route = 3'b010;
                default:     route = 3'b000;
            endcase
        end
    end

    assign out_free          = !out_valid_reg || out_ready;
    assign status.due        = snd_due || sav_due;
    assign status.hold_valid = hold_valid_reg;
    assign status.out_free   = out_free;

    assign push = cmd.flush || (cmd.commit && hold_valid_reg);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

    // tables and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                tx_period_reg[i]    <= TICK_BITS'(DEFAULT_PERIOD);
                store_period_reg[i] <= '0;
                last_send_reg[i]    <= '0;
                last_save_reg[i]    <= '0;
            end
            link_mode_reg    <= LINK_MODE_RESET;
            active_count_reg <= ACTIVE_COUNT_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_LINK_MODE:    link_mode_reg    <= cfg_data[1:0];
                    REG_ACTIVE_COUNT: active_count_reg <= cfg_data[4:0];
                    default:          link_mode_reg    <= link_mode_reg;
                endcase
            end
            if (cmd.wr_send && wr_in_range)
            begin
                tx_period_reg[wr_idx] <= TICK_BITS'(period_value);
            end
            if (cmd.wr_save && wr_in_range)
            begin
                store_period_reg[wr_idx] <= TICK_BITS'(period_value);
            end
            if (cmd.preset_wr)
            begin
                tx_period_reg[cnt[IDX_W-1:0]] <=
                    TICK_BITS'(preset_period(pid_reg, 4'(cnt)));
            end
            if (cmd.commit)
            begin
                if (snd_due)
                begin
                    last_send_reg[rd_idx] <= now_reg;
                end
                if (sav_due)
                begin
                    last_save_reg[rd_idx] <= now_reg;
                end
            end
        end
    end

    // control flags of the held result and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            now_reg <= TICK_BITS'(tick_value);
            pid_reg <= preset_id;
        end
        if (cmd.commit)
        begin
            hold_idx_reg   <= 4'(cnt);
            hold_route_reg <= route;
        end
        if (push)
        begin
            out_data_reg <= {1'b0, hold_route_reg, hold_idx_reg};
            out_last_reg <= cmd.flush;
        end
    end

endmodule

// ----- hw/rtl/periodic_message_scheduler.sv -----
// periodic_message_scheduler: top level, joins controller and datapath and
// unpacks the stream payload. depends on pms_pkg, pms_ctrl and pms_dp.
//
// channel  direction  handshake                      payload
// s_axis   in         s_axis_tvalid / s_axis_tready  tdata: opcode, tick, index, period, preset
// m_axis   out        m_axis_tvalid / m_axis_tready  tdata: index, routes; tlast: last of tick
// cfg      in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// a tick scans the active entries, n being the active entry count saturated to
// MAX_ENTRIES: one table entry is read and tested per cycle through a single read
// port while the scan does not stall, and the scan ends by flushing any held result.
// a preset load writes min(n, 11) entries; a period write does not leave idle.
// reset sets every table to its reset value at once, with no clearing pass.
// a scan stalls on a second due entry while the output register is still full.
module periodic_message_scheduler #(
    parameter int MAX_ENTRIES = pms_pkg::DEF_MAX_ENTRIES,
    parameter int TICK_BITS   = pms_pkg::DEF_TICK_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // [1:0] opcode, [33:2] tick_value, [37:34] entry_index,
    // [69:38] period_value, [72:70] preset_id, [79:73] zero
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [pms_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [3:0] message_index, [4] to_usb, [5] to_radio, [6] to_flash, [7] zero
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [pms_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast,      // last_of_tick
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,         // 0 link_mode, 1 active_count
    input  logic [pms_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pms_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // input fields
    logic [1:0]  opcode;
    logic [31:0] tick_value;
    logic [3:0]  entry_index;
    logic [31:0] period_value;
    logic [2:0]  preset_id;

    pms_cmd_t         cmd;
    pms_status_t      status;
    logic [CNT_W-1:0] cnt;
    logic             in_valid;

    assign opcode       = s_axis_tdata[1:0];
    assign tick_value   = s_axis_tdata[33:2];
    assign entry_index  = s_axis_tdata[37:34];
    assign period_value = s_axis_tdata[69:38];
    assign preset_id    = s_axis_tdata[72:70];

    // the user must change config registers only while idle (not enforced); writes are always taken
    assign cfg_ready = 1'b1;

    // ready is only high while idle, so valid alone marks the transaction
    assign in_valid = s_axis_tvalid;

    pms_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (s_axis_tready),
        .opcode    (opcode),
        .preset_id (preset_id),
        .status    (status),
        .cmd       (cmd),
        .cnt       (cnt)
    );

    pms_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .TICK_BITS   (TICK_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cnt          (cnt),
        .tick_value   (tick_value),
        .entry_index  (entry_index),
        .period_value (period_value),
        .preset_id    (preset_id),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .status       (status),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_data     (m_axis_tdata),
        .out_last     (m_axis_tlast)
    );

endmodule

// ----- hw/rtl/pms_checker.sv -----
// pms_checker: port level assertions for the periodic message scheduler and
// the bind that attaches them. depends on pms_pkg and the top level.
module pms_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [pms_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [pms_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              m_axis_tlast
);
    import pms_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // a tick transaction starts a scan that blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == OP_TICK |=> !s_axis_tready)
        else $error("input ready right after a tick");

    // a valid preset load blocks the input for its sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == OP_PRESET &&
        s_axis_tdata[72:70] >= PRESET_FIRST_ID && s_axis_tdata[72:70] <= PRESET_LAST_ID
        |=> !s_axis_tready)
        else $error("input ready right after a preset load");

    // a period write finishes in its own cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready &&
        (s_axis_tdata[1:0] == OP_WR_SEND || s_axis_tdata[1:0] == OP_WR_SAVE)
        |=> s_axis_tready)
        else $error("period write did not return to idle");

    // usb never goes together with radio or flash
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> !m_axis_tdata[5] && !m_axis_tdata[6])
        else $error("usb route combined with another route");

endmodule

bind periodic_message_scheduler pms_checker u_pms_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
